### design/tpbb_pkg.sv
`default_nettype none

package tpbb_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned RowW     = 3 * CoefW;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgDataW = RowW;
  localparam int unsigned CfgIdxW  = 3;

  // Saturation limit of the pixel counter: the smaller of the pixel bound and the
  // counter's own range.
  localparam int unsigned MaxPixels = 65535;
  localparam int unsigned CountMax  = (1 << CountW) - 1;
  localparam int unsigned PixCap    = (MaxPixels < CountMax) ? MaxPixels : CountMax;

  localparam logic [RowW-1:0]     RotRowReset   = 48'd1073725440;
  localparam logic [CoordW-1:0]   TransReset    = 32'd0;
  localparam logic [CoordW-1:0]   MinRangeReset = 32'd4295;
  localparam logic [CountW-1:0]   MinPixReset   = 16'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRotRow0   = 3'd0,
    CfgRotRow1   = 3'd1,
    CfgRotRow2   = 3'd2,
    CfgTransX    = 3'd3,
    CfgTransY    = 3'd4,
    CfgTransZ    = 3'd5,
    CfgMinRange  = 3'd6,
    CfgMinPixels = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic                     last_of_detection;
  } point_t;

  typedef struct packed {
    logic                     object_valid;
    logic signed [CoordW-1:0] box_min_x;
    logic signed [CoordW-1:0] box_min_y;
    logic signed [CoordW-1:0] box_min_z;
    logic signed [CoordW-1:0] box_max_x;
    logic signed [CoordW-1:0] box_max_y;
    logic signed [CoordW-1:0] box_max_z;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic [CountW-1:0]        kept_count;
  } box_t;

endpackage

`default_nettype wire

### design/tpbb_point_if.sv
`default_nettype none

interface tpbb_point_if;
  import tpbb_pkg::*;

  logic   valid;
  logic   ready;
  point_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/tpbb_box_if.sv
`default_nettype none

interface tpbb_box_if;
  import tpbb_pkg::*;

  logic valid;
  logic ready;
  box_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/transformed_point_bounding_box_core.sv
// Bounding box of one detection's points after a rigid transform. Points enter on pt_i, one per
// cycle, with last_of_detection on the final point; points whose squared range is below
// min_range_sq are dropped, the rest are rotated (Q2.14 rows), translated and saturated, and
// their per-axis extrema are kept. Each point is one transfer and the block takes one per clock:
// a point passes an input register, a multiplier stage, a sum and rounding stage and a translate
// and saturate stage, then updates the accumulators; when a detection's last point leaves the
// last stage, its result is registered into the output register. Input transfers stop only
// while the last point of a detection waits for an output register that still holds the
// previous, untaken result. Configuration is written through cfg_we_i while no point is in flight.
`default_nettype none

module transformed_point_bounding_box_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  tpbb_point_if.sink                     pt_i,
  tpbb_box_if.source                     box_o,
  input  wire                            cfg_we_i,
  input  wire [tpbb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire [tpbb_pkg::CfgDataW-1:0]   cfg_data_i
);
  import tpbb_pkg::*;

  localparam int unsigned ProdW  = CoordW + CoefW;
  localparam int unsigned SumW   = ProdW + 2;
  localparam int unsigned RndW   = SumW - 14;
  localparam int unsigned TranW  = RndW + 1;
  localparam int unsigned SqW    = 2 * CoordW - 1;
  localparam int unsigned RsqW   = 2 * CoordW;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  // Configuration registers.
  logic [RowW-1:0]          rot_q   [3];
  logic signed [CoordW-1:0] trans_q [3];
  logic [CoordW-1:0]        min_rsq_q;
  logic [CountW-1:0]        min_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        rot_q[i]   <= RotRowReset;
        trans_q[i] <= TransReset;
      end
      min_rsq_q <= MinRangeReset;
      min_pix_q <= MinPixReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgRotRow0:   rot_q[0]   <= cfg_data_i[RowW-1:0];
        CfgRotRow1:   rot_q[1]   <= cfg_data_i[RowW-1:0];
        CfgRotRow2:   rot_q[2]   <= cfg_data_i[RowW-1:0];
        CfgTransX:    trans_q[0] <= cfg_data_i[CoordW-1:0];
        CfgTransY:    trans_q[1] <= cfg_data_i[CoordW-1:0];
        CfgTransZ:    trans_q[2] <= cfg_data_i[CoordW-1:0];
        CfgMinRange:  min_rsq_q  <= cfg_data_i[CoordW-1:0];
        CfgMinPixels: min_pix_q  <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic en;
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic s1_last_q, s2_last_q, s3_last_q, s4_last_q;
  logic emit;

  assign en         = !(s4_vld_q && s4_last_q && box_o.valid && !box_o.ready);
  assign pt_i.ready = en;
  assign emit       = en && s4_vld_q && s4_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= pt_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // Stage 1: input register.
  logic signed [CoordW-1:0] p_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0]    <= pt_i.data.px;
      p_q[1]    <= pt_i.data.py;
      p_q[2]    <= pt_i.data.pz;
      s1_last_q <= pt_i.data.last_of_detection;
    end
  end

  // Stage 2: rotation products and squares.
  logic signed [ProdW-1:0]    prod_d [3][3];
  logic signed [ProdW-1:0]    prod_q [3][3];
  logic signed [2*CoordW-1:0] sq_full [3];
  logic [SqW-1:0]             sq_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = ProdW'($signed(rot_q[i][CoefW*j +: CoefW])) * ProdW'(p_q[j]);
      end
      sq_full[i] = RsqW'(p_q[i]) * RsqW'(p_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q    <= prod_d;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= sq_full[i][SqW-1:0];
      end
      s2_last_q <= s1_last_q;
    end
  end

  // Stage 3: row sums rounded to Q16.16, squared range.
  logic signed [SumW-1:0] row_sum [3];
  logic signed [RndW-1:0] rnd_d [3];
  logic signed [RndW-1:0] rnd_q [3];
  logic [RsqW-1:0]        rsq_d;
  logic [RsqW-1:0]        rsq_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = SumW'(prod_q[i][0]) + SumW'(prod_q[i][1]) + SumW'(prod_q[i][2])
                   + SumW'(8192);
      rnd_d[i]   = row_sum[i][SumW-1:14];
    end
    rsq_d = RsqW'(sq_q[0]) + RsqW'(sq_q[1]) + RsqW'(sq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rnd_q     <= rnd_d;
      rsq_q     <= rsq_d;
      s3_last_q <= s2_last_q;
    end
  end

  // Stage 4: translation, saturation and range check.
  logic signed [TranW-1:0]  tr_sum [3];
  logic signed [CoordW-1:0] v_d [3];
  logic signed [CoordW-1:0] v_q [3];
  logic                     keep_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tr_sum[i] = TranW'(rnd_q[i]) + TranW'(trans_q[i]);
      if (tr_sum[i] > TranW'(CoordMax)) begin
        v_d[i] = CoordMax;
      end else if (tr_sum[i] < TranW'(CoordMin)) begin
        v_d[i] = CoordMin;
      end else begin
        v_d[i] = tr_sum[i][CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q       <= v_d;
      keep_q    <= (rsq_q >= RsqW'(min_rsq_q));
      s4_last_q <= s3_last_q;
    end
  end

  // Accumulators and result.
  logic signed [CoordW-1:0] run_min_q [3];
  logic signed [CoordW-1:0] run_max_q [3];
  logic [CountW-1:0]        kept_q, seen_q;
  logic signed [CoordW-1:0] min_d [3];
  logic signed [CoordW-1:0] max_d [3];
  logic [CountW-1:0]        kept_d, seen_d;
  logic                     obj_ok;
  logic signed [CoordW-1:0] lo [3];
  logic signed [CoordW-1:0] hi [3];
  logic signed [CoordW:0]   mid_sum [3];
  box_t                     res_d;
  box_t                     res_q;
  logic                     res_vld_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      min_d[i] = (keep_q && (v_q[i] < run_min_q[i])) ? v_q[i] : run_min_q[i];
      max_d[i] = (keep_q && (v_q[i] > run_max_q[i])) ? v_q[i] : run_max_q[i];
    end
    kept_d = (keep_q && (kept_q != CountW'(CountMax))) ? kept_q + 1'b1 : kept_q;
    seen_d = (seen_q < CountW'(PixCap)) ? seen_q + 1'b1 : seen_q;
  end

  always_comb begin
    obj_ok = (seen_d >= min_pix_q) && (kept_d != '0);
    for (int i = 0; i < 3; i++) begin
      lo[i]      = obj_ok ? min_d[i] : '0;
      hi[i]      = obj_ok ? max_d[i] : '0;
      mid_sum[i] = {lo[i][CoordW-1], lo[i]} + {hi[i][CoordW-1], hi[i]};
    end
    res_d.object_valid = obj_ok;
    res_d.box_min_x    = lo[0];
    res_d.box_min_y    = lo[1];
    res_d.box_min_z    = lo[2];
    res_d.box_max_x    = hi[0];
    res_d.box_max_y    = hi[1];
    res_d.box_max_z    = hi[2];
    res_d.center_x     = mid_sum[0][CoordW:1];
    res_d.center_y     = mid_sum[1][CoordW:1];
    res_d.center_z     = mid_sum[2][CoordW:1];
    res_d.kept_count   = kept_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        run_min_q[i] <= CoordMax;
        run_max_q[i] <= CoordMin;
      end
      kept_q <= '0;
      seen_q <= '0;
    end else if (en && s4_vld_q) begin
      if (s4_last_q) begin
        for (int i = 0; i < 3; i++) begin
          run_min_q[i] <= CoordMax;
          run_max_q[i] <= CoordMin;
        end
        kept_q <= '0;
        seen_q <= '0;
      end else begin
        run_min_q <= min_d;
        run_max_q <= max_d;
        kept_q    <= kept_d;
        seen_q    <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (emit) begin
      res_vld_q <= 1'b1;
    end else if (box_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign box_o.valid = res_vld_q;
  assign box_o.data  = res_q;

  a_kept_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= seen_q)
    else $error("kept count exceeds pixel count");

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kept_q != '0) |-> ((run_min_q[0] <= run_max_q[0]) && (run_min_q[1] <= run_max_q[1])
                        && (run_min_q[2] <= run_max_q[2])))
    else $error("running minimum above running maximum");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(box_o.valid) |-> $past(s4_vld_q && s4_last_q))
    else $error("result appeared without a last point");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pt_i.ready |-> (box_o.valid && !box_o.ready && s4_vld_q && s4_last_q))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

### tb/transformed_point_bounding_box_check.sv
`timescale 1ns / 100ps

module transformed_point_bounding_box_check (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  tpbb_point_if                         pt_i,
  tpbb_box_if                           box_i,
  input  wire                           cfg_we_i,
  input  wire [tpbb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [tpbb_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import tpbb_pkg::*;

  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;

  logic [RowW-1:0]          rot_q [3];
  logic signed [CoordW-1:0] offset_q [3];
  logic [CoordW-1:0]        range_floor_q;
  logic [CountW-1:0]        pixel_floor_q;
  logic signed [CoordW-1:0] lo_q [3];
  logic signed [CoordW-1:0] hi_q [3];
  logic [CountW-1:0]        kept_q;
  logic [CountW-1:0]        seen_q;
  box_t                     boxes_due [$];

  function automatic logic signed [CoordW-1:0] midpoint(input logic signed [CoordW-1:0] lo,
                                                        input logic signed [CoordW-1:0] hi);
    logic signed [CoordW:0] total;
    total = (CoordW+1)'(lo) + (CoordW+1)'(hi);
    return total[CoordW:1];
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    logic signed [63:0]       wx, wy, wz, acc;
    logic signed [CoefW-1:0]  c0, c1, c2;
    logic [63:0]              range_sq;
    logic signed [CoordW-1:0] v;
    logic signed [CoordW-1:0] lo_v [3];
    logic signed [CoordW-1:0] hi_v [3];
    logic                     fit;
    box_t                     want, got;
    int                       a;
    if (!rst_ni) begin
      for (a = 0; a < 3; a++) begin
        rot_q[a]    = RotRowReset;
        offset_q[a] = TransReset;
        lo_q[a]     = CoordMax;
        hi_q[a]     = CoordMin;
      end
      range_floor_q = MinRangeReset;
      pixel_floor_q = MinPixReset;
      kept_q        = '0;
      seen_q        = '0;
      boxes_due.delete();
      fail_count_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRotRow0:   rot_q[0] = cfg_data_i;
          CfgRotRow1:   rot_q[1] = cfg_data_i;
          CfgRotRow2:   rot_q[2] = cfg_data_i;
          CfgTransX:    offset_q[0] = cfg_data_i[CoordW-1:0];
          CfgTransY:    offset_q[1] = cfg_data_i[CoordW-1:0];
          CfgTransZ:    offset_q[2] = cfg_data_i[CoordW-1:0];
          CfgMinRange:  range_floor_q = cfg_data_i[CoordW-1:0];
          CfgMinPixels: pixel_floor_q = cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end

      if (pt_i.valid && pt_i.ready) begin
        wx = 64'($signed(pt_i.data.px));
        wy = 64'($signed(pt_i.data.py));
        wz = 64'($signed(pt_i.data.pz));
        range_sq = wx * wx + wy * wy + wz * wz;
        if (seen_q < CountW'(PixCap)) seen_q++;
        if (range_sq >= {32'd0, range_floor_q}) begin
          for (a = 0; a < 3; a++) begin
            c0  = rot_q[a][CoefW-1:0];
            c1  = rot_q[a][2*CoefW-1:CoefW];
            c2  = rot_q[a][3*CoefW-1:2*CoefW];
            acc = 64'(c0) * wx + 64'(c1) * wy + 64'(c2) * wz;
            // Round half up from Q18.30 to Q16.16, then translate and saturate.
            acc = ((acc + 64'sd8192) >>> 14) + 64'(offset_q[a]);
            if (acc > 64'sd2147483647) begin
              v = CoordMax;
            end else if (acc < -64'sd2147483648) begin
              v = CoordMin;
            end else begin
              v = acc[CoordW-1:0];
            end
            if (v < lo_q[a]) lo_q[a] = v;
            if (v > hi_q[a]) hi_q[a] = v;
          end
          if (kept_q != '1) kept_q++;
        end

        if (pt_i.data.last_of_detection) begin
          fit = (seen_q >= pixel_floor_q) && (kept_q != '0);
          for (a = 0; a < 3; a++) begin
            lo_v[a] = fit ? lo_q[a] : '0;
            hi_v[a] = fit ? hi_q[a] : '0;
          end
          want.object_valid = fit;
          want.box_min_x    = lo_v[0];
          want.box_min_y    = lo_v[1];
          want.box_min_z    = lo_v[2];
          want.box_max_x    = hi_v[0];
          want.box_max_y    = hi_v[1];
          want.box_max_z    = hi_v[2];
          want.center_x     = midpoint(lo_v[0], hi_v[0]);
          want.center_y     = midpoint(lo_v[1], hi_v[1]);
          want.center_z     = midpoint(lo_v[2], hi_v[2]);
          want.kept_count   = kept_q;
          boxes_due.push_back(want);
          for (a = 0; a < 3; a++) begin
            lo_q[a] = CoordMax;
            hi_q[a] = CoordMin;
          end
          kept_q = '0;
          seen_q = '0;
        end
      end

      if (box_i.valid && box_i.ready) begin
        got = box_i.data;
        if (boxes_due.size() == 0) begin
          $error("box transfer with no detection closed, kept_count %0d", got.kept_count);
          fail_count_o++;
        end else begin
          want = boxes_due.pop_front();
          check_field("object_valid", longint'(want.object_valid),
                      longint'(got.object_valid));
          check_field("box_min_x", longint'(want.box_min_x), longint'(got.box_min_x));
          check_field("box_min_y", longint'(want.box_min_y), longint'(got.box_min_y));
          check_field("box_min_z", longint'(want.box_min_z), longint'(got.box_min_z));
          check_field("box_max_x", longint'(want.box_max_x), longint'(got.box_max_x));
          check_field("box_max_y", longint'(want.box_max_y), longint'(got.box_max_y));
          check_field("box_max_z", longint'(want.box_max_z), longint'(got.box_max_z));
          check_field("center_x", longint'(want.center_x), longint'(got.center_x));
          check_field("center_y", longint'(want.center_y), longint'(got.center_y));
          check_field("center_z", longint'(want.center_z), longint'(got.center_z));
          check_field("kept_count", longint'(want.kept_count), longint'(got.kept_count));
        end
      end
    end
    pending_o = boxes_due.size();
  end

endmodule

### tb/transformed_point_bounding_box_core_tb.sv
`timescale 1ns / 100ps

module transformed_point_bounding_box_core_tb;
  import tpbb_pkg::*;

  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 10;
  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                cfg_we   = 1'b0;
  cfg_idx_e            cfg_idx  = CfgRotRow0;
  logic [CfgDataW-1:0] cfg_data = '0;
  bit                  sender_idles   = 1'b0;
  bit                  receiver_idles = 1'b0;
  bit                  hold_req       = 1'b0;
  int                  fail_count;
  int                  pending;

  tpbb_point_if pt ();
  tpbb_box_if   box ();

  always #4 clk = ~clk;

  transformed_point_bounding_box_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pt_i       (pt),
    .box_o      (box),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  transformed_point_bounding_box_check box_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .pt_i         (pt),
    .box_i        (box),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int unsigned gap_cycles();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 40);
  endfunction

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5: return $urandom_range(0, 131072) - 65536;
      6, 7:    return $urandom_range(0, 1024) - 512;
      default: begin
        case ($urandom_range(0, 3))
          0:       return CoordMax;
          1:       return CoordMin;
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [RowW-1:0] rand_row();
    logic [RowW-1:0] r;
    int              j;
    for (j = 0; j < 3; j++) begin
      case ($urandom_range(0, 7))
        0:       r[j*CoefW +: CoefW] = 16'h8000;
        1:       r[j*CoefW +: CoefW] = 16'h7FFF;
        2:       r[j*CoefW +: CoefW] = 16'h4000;
        3:       r[j*CoefW +: CoefW] = 16'hC000;
        4:       r[j*CoefW +: CoefW] = '0;
        default: r[j*CoefW +: CoefW] = CoefW'($urandom);
      endcase
    end
    return r;
  endfunction

  // The point stays offered until a transfer; ready is judged at the falling edge.
  task automatic offer_point(input point_t p);
    pt.valid <= 1'b1;
    pt.data  <= p;
    do @(negedge clk); while (!pt.ready);
    @(posedge clk);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      pt.valid <= 1'b0;
      repeat (gap_cycles()) @(posedge clk);
    end
  endtask

  task automatic drain();
    pt.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_put(input cfg_idx_e idx, input logic [CfgDataW-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  // Bits above each register's width carry junk that the block must ignore.
  task automatic program_regs(input logic [RowW-1:0] r0, input logic [RowW-1:0] r1,
                              input logic [RowW-1:0] r2, input logic [CoordW-1:0] tx,
                              input logic [CoordW-1:0] ty, input logic [CoordW-1:0] tz,
                              input logic [CoordW-1:0] rng, input logic [CountW-1:0] pix);
    cfg_put(CfgRotRow0, r0);
    cfg_put(CfgRotRow1, r1);
    cfg_put(CfgRotRow2, r2);
    cfg_put(CfgTransX, {16'($urandom), tx});
    cfg_put(CfgTransY, {16'($urandom), ty});
    cfg_put(CfgTransZ, {16'($urandom), tz});
    cfg_put(CfgMinRange, {16'($urandom), rng});
    cfg_put(CfgMinPixels, {32'($urandom), pix});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_detections(input int unsigned n_points);
    point_t      p;
    int unsigned len, sent, k;
    sent = 0;
    while (sent < n_points) begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      for (k = 0; k < len; k++) begin
        p.px = rand_coord();
        p.py = rand_coord();
        p.pz = rand_coord();
        p.last_of_detection = (k == len - 1);
        offer_point(p);
      end
      sent += len;
    end
  endtask

  initial begin : result_taker
    box.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        box.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        box.ready <= 1'b0;
        repeat (gap_cycles()) @(posedge clk);
      end else begin
        box.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((pt.valid && pt.ready) || (box.valid && box.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    point_t      p;
    int          k;
    int unsigned phase;
    logic [CoordW-1:0] rng;
    pt.valid = 1'b0;
    pt.data  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings from reset: a lone point at the origin, nine points (too few pixels),
    // then ten points over the coordinate corners with two that fall below the range.
    p = '{px: '0, py: '0, pz: '0, last_of_detection: 1'b1};
    offer_point(p);
    for (k = 0; k < 9; k++) begin
      p.px = rand_coord();
      p.py = rand_coord();
      p.pz = rand_coord();
      p.last_of_detection = (k == 8);
      offer_point(p);
    end
    for (k = 0; k < 10; k++) begin
      p.px = k[0] ? CoordMax : CoordMin;
      p.py = k[1] ? CoordMax : CoordMin;
      p.pz = k[2] ? CoordMax : CoordMin;
      if (k >= 8) begin
        p.px = k - 8;
        p.py = -(k - 8);
        p.pz = '0;
      end
      p.last_of_detection = (k == 9);
      offer_point(p);
    end
    drain();

    // Rounding ties in both directions, with no range floor and no pixel floor.
    program_regs(48'h0000_4000_0001, 48'h4000_0000_0000, 48'h0000_0000_4000,
                 '0, '0, '0, '0, '0);
    p = '{px: 32'sh2000, py: '0, pz: '0, last_of_detection: 1'b0};
    offer_point(p);
    p = '{px: -32'sh2000, py: 32'sh1_0000, pz: -32'sd5, last_of_detection: 1'b1};
    offer_point(p);
    drain();

    // Extreme coefficients and offsets drive the transform into saturation.
    program_regs({3{16'h8000}}, {3{16'h7FFF}}, {16'h0000, 16'h8000, 16'h7FFF},
                 CoordMax, CoordMin, '0, 32'hFFFF_FFFF, 16'hFFFF);
    p = '{px: CoordMax, py: CoordMax, pz: CoordMax, last_of_detection: 1'b0};
    offer_point(p);
    p = '{px: CoordMin, py: CoordMin, pz: CoordMin, last_of_detection: 1'b0};
    offer_point(p);
    p = '{px: 32'sh100, py: '0, pz: '0, last_of_detection: 1'b1};
    offer_point(p);
    drain();

    for (phase = 0; phase < 6; phase++) begin
      sender_idles   = (phase != 3);
      receiver_idles = (phase != 3);
      case ($urandom_range(0, 3))
        0:       rng = '0;
        1:       rng = $urandom_range(0, 1 << 20);
        2:       rng = $urandom;
        default: rng = '1;
      endcase
      program_regs(rand_row(), rand_row(), rand_row(), rand_coord(), rand_coord(), rand_coord(),
                   rng, CountW'(($urandom_range(0, 7) < 6) ? $urandom_range(0, 12) : $urandom));
      if (phase == 2) begin
        sender_idles = 1'b0;
        hold_req     = 1'b1;
      end
      send_detections(80);
      drain();
      send_detections(75);
      drain();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
